// ===== design/cwd_pkg.sv =====
// Shared types and constants for the credit window distributor.
// No dependencies; imported by every module of the block.
package cwd_pkg;

  localparam int MAX_LINKS = 16;
  localparam int LINK_W    = 4;                        // link_index field width
  localparam int CNT_W     = $clog2(MAX_LINKS + 1);    // link count incl. MAX_LINKS
  localparam int CRED_W    = 16;                       // window, residual, capacity
  localparam int REM_CRED_W = 24;
  localparam int TOT_W     = REM_CRED_W + 1;           // local + remote credit
  localparam int DIV_W     = CRED_W + 1;               // local + remote links
  localparam int STEP_W    = $clog2(TOT_W + 1);

  localparam logic [CRED_W-1:0] CAP_RESET = CRED_W'(250);
  localparam logic [CRED_W-1:0] CRED_MAX  = {CRED_W{1'b1}};

  // Work handed from the front (target computation) to the back (link walk)
  typedef struct packed {
    logic [CRED_W-1:0] target;
    logic [CNT_W-1:0]  nlinks;
  } cwd_job_t;

endpackage

// ===== design/credit_window_distributor_top.sv =====
// Top level of the credit window distributor: capacity register, front end,
// job queue and back end. Depends on cwd_pkg, cwd_front, cwd_queue, cwd_back.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | has_direct_destination, local_credit,
//          |                       | remote_credit, local_inlinks,
//          |                       | remote_links
//  out     | out_valid / out_stall | link_index, new_window, issued_credit, last
//  cfg     | cfg_valid / cfg_ready | cfg_data (link_capacity)
//
// An event with a direct destination goes from its beat to the F_PUSH state;
// otherwise the restoring divider runs first (one quotient bit a cycle).
// The back end then emits one result beat per active link per cycle unless
// out_stall holds it; the front may divide the next event meanwhile.
// Reset (rst, synchronous) clears all windows and residuals and sets capacity to 250.
// out_stall holds the result register and pauses the link walk; in_stall is high
// whenever the front is busy. cfg_ready is always high.
module credit_window_distributor_top
  import cwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  has_direct_destination,
  input  logic [CRED_W-1:0]     local_credit,
  input  logic [REM_CRED_W-1:0] remote_credit,
  input  logic [CNT_W-1:0]      local_inlinks,
  input  logic [CRED_W-1:0]     remote_links,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LINK_W-1:0]     link_index,
  output logic [CRED_W-1:0]     new_window,
  output logic [CRED_W-1:0]     issued_credit,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CRED_W-1:0]     cfg_data
);

  logic [CRED_W-1:0] capacity;
  logic              q_push, q_full, q_pop, q_nonempty;
  cwd_job_t          q_in, q_out;

  // Capacity register: take every cfg beat
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Front: drop empty events, form the target credit
  cwd_front u_front (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .has_direct_destination (has_direct_destination),
    .local_credit           (local_credit),
    .remote_credit          (remote_credit),
    .local_inlinks          (local_inlinks),
    .remote_links           (remote_links),
    .capacity               (capacity),
    .push                   (q_push),
    .push_data              (q_in),
    .full                   (q_full)
  );

  // Decouple target computation from the link walk
  cwd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .nonempty  (q_nonempty)
  );

  // Back: advance over active links, update tables, emit beats
  cwd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .capacity      (capacity),
    .q_nonempty    (q_nonempty),
    .q_data        (q_out),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .link_index    (link_index),
    .new_window    (new_window),
    .issued_credit (issued_credit),
    .last          (last)
  );

endmodule

// ===== design/cwd_front.sv =====
// Front end: accepts flow-change beats, drops empty ones and forms the target.
// Uses cwd_pkg; contains a one-bit-per-cycle restoring divider.
module cwd_front
  import cwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  has_direct_destination,
  input  logic [CRED_W-1:0]     local_credit,
  input  logic [REM_CRED_W-1:0] remote_credit,
  input  logic [CNT_W-1:0]      local_inlinks,
  input  logic [CRED_W-1:0]     remote_links,
  input  logic [CRED_W-1:0]     capacity,
  output logic                  push,
  output cwd_job_t              push_data,
  input  logic                  full
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t           state;
  logic [TOT_W-1:0]  dq;        // dividend shifting out, quotient shifting in
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic              total_zero;
  cwd_job_t          job;

  logic [CNT_W-1:0]  n_clamped;
  logic [TOT_W-1:0]  total;
  logic [DIV_W:0]    trial;
  logic              take;
  logic              accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != F_IDLE);
  assign n_clamped = (local_inlinks > CNT_W'(MAX_LINKS)) ? CNT_W'(MAX_LINKS) : local_inlinks;
  assign total     = TOT_W'(local_credit) + TOT_W'(remote_credit);
  assign trial     = {rem, dq[TOT_W-1]};
  assign take      = (trial >= {1'b0, divisor});

  assign push      = (state == F_PUSH) && !full;
  assign push_data = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && n_clamped != '0) begin
            job.nlinks <= n_clamped;
            if (has_direct_destination) begin
              job.target <= capacity;
              state      <= F_PUSH;
            end else begin
              dq         <= total;
              rem        <= '0;
              divisor    <= DIV_W'(n_clamped) + DIV_W'(remote_links);
              step       <= STEP_W'(TOT_W);
              total_zero <= (total == '0);
              state      <= F_DIV;
            end
          end
        end
        F_DIV: begin
          if (step != '0) begin
            rem  <= take ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
            dq   <= {dq[TOT_W-2:0], take};
            step <= step - 1'b1;
          end else begin
            // zero total gives zero; else floor the quotient at 1 and saturate it to the credit width
            if (total_zero) begin
              job.target <= '0;
            end else if (dq == '0) begin
              job.target <= CRED_W'(1);
            end else if (dq[TOT_W-1:CRED_W] != '0) begin
              job.target <= CRED_MAX;
            end else begin
              job.target <= dq[CRED_W-1:0];
            end
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== design/cwd_queue.sv =====
// Two-entry job queue between front and back.
// Uses cwd_pkg for the job type.
module cwd_queue
  import cwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cwd_job_t push_data,
  output logic     full,
  input  logic     pop,
  output cwd_job_t pop_data,
  output logic     nonempty
);

  cwd_job_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== design/cwd_back.sv =====
// Back end: walks the active links of one job, updates window and residual,
// and presents one result beat per link. Uses cwd_pkg.
module cwd_back
  import cwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CRED_W-1:0] capacity,
  input  logic              q_nonempty,
  input  cwd_job_t          q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LINK_W-1:0] link_index,
  output logic [CRED_W-1:0] new_window,
  output logic [CRED_W-1:0] issued_credit,
  output logic              last
);

  logic              busy;
  cwd_job_t          job;
  logic [LINK_W-1:0] idx;
  logic [CRED_W-1:0] window   [MAX_LINKS];
  logic [CRED_W-1:0] residual [MAX_LINKS];

  logic              advance;
  logic              last_link;
  logic [CRED_W-1:0] tgt, win, res, grow;
  logic [CRED_W-1:0] win_next, res_next, issued_next;
  logic [CRED_W:0]   res_sum;

  assign pop       = !busy && q_nonempty;
  assign advance   = busy && (!out_valid || !out_stall);
  assign last_link = ({1'b0, idx} == CNT_W'(job.nlinks - 1'b1));

  always_comb begin
    tgt         = (job.target > capacity) ? capacity : job.target;
    win         = window[idx];
    res         = residual[idx];
    grow        = tgt - win;
    res_sum     = {1'b0, res} + {1'b0, win - tgt};
    win_next    = tgt;
    res_next    = res;
    issued_next = '0;
    if (tgt > win) begin
      if (grow > res) begin
        issued_next = grow - res;
        res_next    = '0;
      end else begin
        res_next = res - grow;
      end
    end else if (tgt < win) begin
      res_next = res_sum[CRED_W] ? CRED_MAX : res_sum[CRED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_LINKS; i++) begin
        window[i]   <= '0;
        residual[i] <= '0;
      end
    end else begin
      if (pop) begin
        job  <= q_data;
        idx  <= '0;
        busy <= 1'b1;
      end
      if (advance) begin
        window[idx]   <= win_next;
        residual[idx] <= res_next;
        link_index    <= idx;
        new_window    <= win_next;
        issued_credit <= issued_next;
        last          <= last_link;
        out_valid     <= 1'b1;
        idx           <= idx + 1'b1;
        if (last_link) busy <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
      busy |-> ({1'b0, idx} < job.nlinks))
    else $error("link walk beyond active links");
  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_stall && !last) |-> busy)
    else $error("walk ended before last beat");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
      pop |=> (busy && idx == '0))
    else $error("job pop did not start a walk");

endmodule
